[sv/slp_pkg.sv]
`default_nettype none

package slp_pkg;

  localparam int NAME_LEN = 64;
  localparam int IDX_W    = $clog2(NAME_LEN);
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = 32;
  localparam int MAXA_W   = 16;

  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  len;
    logic [ADDR_W-1:0] addr;
    logic              bad;
    logic              trunc;
  } slp_run_t;

endpackage

`default_nettype wire

[sv/slp_ram.sv]
`default_nettype none

module slp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/slp_parse.sv]
`default_nettype none

module slp_parse
  import slp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire logic [7:0]        text_byte,
  input  wire logic              cfg_wr_en,
  input  wire logic [MAXA_W-1:0] cfg_wr_data,
  output logic                   ram_we,
  output logic [IDX_W-1:0]       ram_waddr,
  output logic [7:0]             ram_wdata,
  output slp_run_t               run
);

  localparam logic [7:0] CH_SQUARE = 8'h5B;
  localparam logic [7:0] CH_CURLY  = 8'h7B;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LONG   = 8'h4C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    ST_GROUND,
    ST_SQUARE,
    ST_CURLY,
    ST_NAME,
    ST_LONG,
    ST_NAME_END,
    ST_VALUE,
    ST_COMMA
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    name_count;
  logic                overflow_seen;
  logic [ADDR_W-1:0]   value_accum;
  logic [MAXA_W-1:0]   addr_limit;
  logic                is_space;
  logic                is_digit;
  logic                full;
  logic [ADDR_W-1:0]   accum_next;

  always_comb begin
    is_space = (text_byte == 8'h20) || (text_byte == 8'h09) || (text_byte == 8'h0D) ||
               (text_byte == 8'h0A) || (text_byte == 8'h00);
    is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    full     = name_count >= CNT_W'(NAME_LEN);
    accum_next = (value_accum << 3) + (value_accum << 1) +
                 ADDR_W'(text_byte[3:0]);
  end

  assign ram_we    = fire && (state == ST_NAME) && (text_byte != CH_QUOTE) && !full;
  assign ram_waddr = name_count[IDX_W-1:0];
  assign ram_wdata = text_byte;

  always_comb begin
    run.start = fire && (state == ST_VALUE) &&
                ((text_byte == CH_LONG) || (text_byte == CH_COMMA));
    run.len   = name_count;
    run.addr  = value_accum;
    run.bad   = value_accum > ADDR_W'(addr_limit);
    run.trunc = overflow_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr_limit <= '1;
    end else if (cfg_wr_en) begin
      addr_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_GROUND;
      name_count    <= '0;
      overflow_seen <= 1'b0;
      value_accum   <= '0;
    end else if (fire) begin
      unique case (state)
        ST_GROUND: begin
          if (text_byte == CH_SQUARE) state <= ST_SQUARE;
        end
        ST_SQUARE: begin
          if (text_byte == CH_CURLY) state <= ST_CURLY;
          else if (text_byte != CH_SQUARE) state <= ST_GROUND;
        end
        ST_CURLY: begin
          if (text_byte == CH_QUOTE) begin
            name_count    <= '0;
            overflow_seen <= 1'b0;
            state         <= ST_NAME;
          end else if (!is_space) begin
            state <= ST_GROUND;
          end
        end
        ST_NAME: begin
          if (text_byte == CH_QUOTE) begin
            state <= ST_NAME_END;
          end else if (full) begin
            overflow_seen <= 1'b1;
            state         <= ST_LONG;
          end else begin
            name_count <= name_count + 1'b1;
          end
        end
        ST_LONG: begin
          if (text_byte == CH_QUOTE) state <= ST_NAME_END;
        end
        ST_NAME_END: begin
          if (text_byte == CH_COLON) begin
            value_accum <= '0;
            state       <= ST_VALUE;
          end else if (!is_space) begin
            state <= ST_GROUND;
          end
        end
        ST_VALUE: begin
          priority if (is_digit) value_accum <= accum_next;
          else if (text_byte == CH_LONG) state <= ST_COMMA;
          else if (text_byte == CH_COMMA) state <= ST_CURLY;
          else state <= ST_GROUND;
        end
        ST_COMMA: begin
          if (text_byte == CH_COMMA) state <= ST_CURLY;
          else if (!is_space) state <= ST_GROUND;
        end
        default: state <= ST_GROUND;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/slp_emit.sv]
`default_nettype none

module slp_emit
  import slp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire slp_run_t    run,
  output logic             busy,
  output logic [IDX_W-1:0] ram_raddr,
  input  wire logic [7:0]  ram_rdata,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       name_char,
  output logic             char_valid,
  output logic [CNT_W-1:0] name_length,
  output logic [ADDR_W-1:0] symbol_address,
  output logic             address_bad,
  output logic             name_truncated,
  output logic             last_of_run
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_LOAD,
    S_SHOW
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  rd_idx;
  logic              pre_ok;
  logic [ADDR_W-1:0] run_addr;
  logic              run_bad;
  logic              run_trunc;
  logic              is_last;

  assign busy      = state != S_IDLE;
  assign ram_raddr = rd_idx[IDX_W-1:0];
  assign is_last   = (rd_idx + 1'b1) == name_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pre_ok    <= 1'b0;
      rd_idx    <= '0;
    end else begin
      // payload of the next output word: a name byte, or the run fields at run start
      if ((state == S_LOAD) ||
          ((state == S_SHOW) && out_ready && !last_of_run && pre_ok)) begin
        name_char      <= ram_rdata;
        char_valid     <= 1'b1;
        symbol_address <= is_last ? run_addr : '0;
        address_bad    <= is_last && run_bad;
        name_truncated <= is_last && run_trunc;
        last_of_run    <= is_last;
      end else if ((state == S_IDLE) && run.start) begin
        name_length    <= run.len;
        run_addr       <= run.addr;
        run_bad        <= run.bad;
        run_trunc      <= run.trunc;
        name_char      <= '0;
        char_valid     <= 1'b0;
        symbol_address <= run.addr;
        address_bad    <= run.bad;
        name_truncated <= run.trunc;
        last_of_run    <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (run.start) begin
            rd_idx <= '0;
            if (run.len == '0) begin
              out_valid <= 1'b1;
              pre_ok    <= 1'b0;
              state     <= S_SHOW;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: state <= S_LOAD;
        S_LOAD: begin
          rd_idx    <= rd_idx + 1'b1;
          out_valid <= 1'b1;
          pre_ok    <= 1'b0;
          state     <= S_SHOW;
        end
        S_SHOW: begin
          pre_ok <= 1'b1;
          if (out_ready) begin
            priority if (last_of_run) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else if (pre_ok) begin
              rd_idx <= rd_idx + 1'b1;
              pre_ok <= 1'b0;
            end else begin
              out_valid <= 1'b0;
              state     <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/symbol_list_parser_top.sv]
// channel   | handshake             | payload
// ----------+-----------------------+--------------------------------------------
// input     | in_valid / in_ready   | text_byte
// output    | out_valid / out_ready | name_char, char_valid, name_length,
//           |                       | symbol_address, address_bad,
//           |                       | name_truncated, last_of_run
// config    | cfg_wr_en             | cfg_wr_data (address limit)
//
// Text bytes are taken one per cycle while no run is being sent.
// A completed entry sends its run from the name RAM, one word per name byte, each a RAM
// read then an output load; an empty name sends a single word.
// in_ready is low from the closing byte until the last word of the run is taken.
// Synchronous reset, no clearing pass; the address limit resets to 65535.
`default_nettype none

module symbol_list_parser_top
  import slp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        text_byte,
  input  wire logic              cfg_wr_en,
  input  wire logic [MAXA_W-1:0] cfg_wr_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             name_char,
  output logic                   char_valid,
  output logic [CNT_W-1:0]       name_length,
  output logic [ADDR_W-1:0]      symbol_address,
  output logic                   address_bad,
  output logic                   name_truncated,
  output logic                   last_of_run
);

  logic             busy;
  logic             fire;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [7:0]       ram_rdata;
  slp_run_t         run;

  assign in_ready = !busy;
  assign fire     = in_valid && in_ready;

  slp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .text_byte   (text_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .run         (run)
  );

  slp_ram #(
    .WIDTH (8),
    .DEPTH (NAME_LEN)
  ) u_name_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  slp_emit u_emit (
    .clk            (clk),
    .rst            (rst),
    .run            (run),
    .busy           (busy),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .name_char      (name_char),
    .char_valid     (char_valid),
    .name_length    (name_length),
    .symbol_address (symbol_address),
    .address_bad    (address_bad),
    .name_truncated (name_truncated),
    .last_of_run    (last_of_run)
  );

  a_no_input_during_run: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a run is pending");

  a_empty_is_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !char_valid) |-> (last_of_run && (name_length == '0)))
    else $error("empty-name word not alone in its run");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run) |=> (!out_valid && in_ready))
    else $error("run did not end after its last word");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (name_length <= CNT_W'(NAME_LEN)))
    else $error("name length beyond buffer");

endmodule

`default_nettype wire
